/* hw/rtl/bimc_pkg.sv */
// ----------------------------------------------------------------------------
// bimc_pkg
// Shared types, constants and helpers for the boot image word checksum block.
// ----------------------------------------------------------------------------
package bimc_pkg;

    localparam int unsigned WORD_W        = 32;
    localparam int unsigned ROT_W         = 5;
    localparam logic [WORD_W-1:0] SEED_RESET = 32'hf8ca4ddc;
    localparam int unsigned MID_DEPTH_DEF = 4;
    localparam int unsigned OUT_DEPTH_DEF = 2;

    typedef struct packed {
        logic [WORD_W-1:0] data_word;
        logic              last_word;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] check_high;
        logic [WORD_W-1:0] check_low;
    } t_out_item;

    // word as classified by the front end, with its rotation already done
    typedef struct packed {
        logic [WORD_W-1:0] data_word;
        logic [WORD_W-1:0] rot_word;
        logic              last_word;
    } t_work_item;

    // occupancy flags of a queue
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [WORD_W-1:0] rotl_self(input logic [WORD_W-1:0] w);
        logic [2*WORD_W-1:0] dbl;
        dbl = {w, w} << w[ROT_W-1:0];
        return dbl[2*WORD_W-1:WORD_W];
    endfunction

endpackage

/* hw/rtl/bimc_fifo.sv */
// ----------------------------------------------------------------------------
// bimc_fifo
// Small synchronous queue of register entries, one push and one pop a cycle.
// ----------------------------------------------------------------------------
module bimc_fifo #(
    parameter int unsigned DEPTH = bimc_pkg::MID_DEPTH_DEF,
    parameter type t_item = bimc_pkg::t_work_item
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  t_item                i_wdata,
    input  logic                 i_pop,
    output t_item                o_rdata,
    output bimc_pkg::t_q_status  o_status
);
    import bimc_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    assign o_rdata        = r_mem[r_rptr];
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_status.full || i_pop)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("pop from empty queue");

endmodule

/* hw/rtl/bimc_front.sv */
// ----------------------------------------------------------------------------
// bimc_front
// Input stage: takes image words, rotates each by its low bits, feeds the
// work queue.
// ----------------------------------------------------------------------------
module bimc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    input  bimc_pkg::t_in_item   i_data,
    output logic                 full,
    input  bimc_pkg::t_q_status  i_q_status,
    output logic                 o_q_push,
    output bimc_pkg::t_work_item o_q_item
);
    import bimc_pkg::*;

    logic       r_valid, n_valid;
    t_work_item r_item;
    logic       accept;

    assign o_q_push = r_valid && !i_q_status.full;
    assign full     = r_valid && i_q_status.full;
    assign accept   = push && !full;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_q_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.data_word <= i_data.data_word;
            r_item.rot_word  <= rotl_self(i_data.data_word);
            r_item.last_word <= i_data.last_word;
        end
    end

    assign o_q_item = r_item;

endmodule

/* hw/rtl/bimc_back.sv */
// ----------------------------------------------------------------------------
// bimc_back
// Accumulator engine: while the result queue has room, folds one queued word
// a cycle into six accumulators; emits the checksum pair on the last word.
// ----------------------------------------------------------------------------
module bimc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [31:0]          i_cfg_wdata,
    input  bimc_pkg::t_q_status  i_mid_status,
    input  bimc_pkg::t_work_item i_mid_item,
    output logic                 o_mid_pop,
    input  bimc_pkg::t_q_status  i_out_status,
    output logic                 o_out_push,
    output bimc_pkg::t_out_item  o_out_item
);
    import bimc_pkg::*;

    logic [WORD_W-1:0] r_seed;
    logic [WORD_W-1:0] r_running_sum, r_carry_count, r_xor_total;
    logic [WORD_W-1:0] r_rotated_sum, r_chosen_xor, r_mixed_sum;

    logic [WORD_W-1:0] n_running_sum, n_carry_count, n_xor_total;
    logic [WORD_W-1:0] n_rotated_sum, n_chosen_xor, n_mixed_sum;
    logic [WORD_W:0]   sum_wide;
    logic [WORD_W-1:0] w;

    assign w         = i_mid_item.data_word;
    // hold off while the result queue is full, so a last word always has room
    assign o_mid_pop = !i_mid_status.empty && !i_out_status.full;
    assign o_out_push = o_mid_pop && i_mid_item.last_word;

    always_comb begin
        sum_wide      = {1'b0, r_running_sum} + {1'b0, w};
        n_running_sum = sum_wide[WORD_W-1:0];
        n_carry_count = r_carry_count + WORD_W'(sum_wide[WORD_W]);
        n_xor_total   = r_xor_total ^ w;
        n_rotated_sum = r_rotated_sum + i_mid_item.rot_word;
        if (w < r_chosen_xor) begin
            n_chosen_xor = r_chosen_xor ^ i_mid_item.rot_word;
        end else begin
            n_chosen_xor = r_chosen_xor ^ n_running_sum ^ w;
        end
        n_mixed_sum = r_mixed_sum + (w ^ n_rotated_sum);
    end

    assign o_out_item.check_high = n_running_sum ^ n_carry_count ^ n_xor_total;
    assign o_out_item.check_low  = n_rotated_sum ^ n_chosen_xor ^ n_mixed_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SEED_RESET;
        end else if (i_cfg_we) begin
            r_seed <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running_sum <= SEED_RESET;
            r_carry_count <= SEED_RESET;
            r_xor_total   <= SEED_RESET;
            r_rotated_sum <= SEED_RESET;
            r_chosen_xor  <= SEED_RESET;
            r_mixed_sum   <= SEED_RESET;
        end else if (o_mid_pop) begin
            if (i_mid_item.last_word) begin
                r_running_sum <= r_seed;
                r_carry_count <= r_seed;
                r_xor_total   <= r_seed;
                r_rotated_sum <= r_seed;
                r_chosen_xor  <= r_seed;
                r_mixed_sum   <= r_seed;
            end else begin
                r_running_sum <= n_running_sum;
                r_carry_count <= n_carry_count;
                r_xor_total   <= n_xor_total;
                r_rotated_sum <= n_rotated_sum;
                r_chosen_xor  <= n_chosen_xor;
                r_mixed_sum   <= n_mixed_sum;
            end
        end
    end

    a_result_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_push |-> !i_out_status.full)
        else $error("result pushed into full queue");
    a_reseed_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mid_pop && i_mid_item.last_word |=>
            r_running_sum == $past(r_seed) && r_mixed_sum == $past(r_seed)
            && r_chosen_xor == $past(r_seed))
        else $error("accumulators not reseeded after last word");
    a_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_mid_pop |=> $stable(r_running_sum) && $stable(r_rotated_sum))
        else $error("accumulators moved without a word");

endmodule

/* hw/rtl/boot_image_word_checksum_top.sv */
// path: a word marked last goes through the front register and the work queue;
//   the result queue then takes its result and empty goes low, given room
// throughput: one word per cycle, set by the accumulator update in the back end;
//   it stalls only while the result queue is full
// reset: synchronous active low; queues empty, seed and all six accumulators
//   load 0xf8ca4ddc; no clearing pass
// ----------------------------------------------------------------------------
// boot_image_word_checksum_top
// Boot image word checksum: front stage, work queue, accumulator back end and
// result queue.
// ----------------------------------------------------------------------------
module boot_image_word_checksum_top #(
    parameter int unsigned MID_DEPTH = bimc_pkg::MID_DEPTH_DEF,
    parameter int unsigned OUT_DEPTH = bimc_pkg::OUT_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [31:0]         i_cfg_wdata,
    input  logic                push,
    input  bimc_pkg::t_in_item  i_data,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output bimc_pkg::t_out_item o_result
);
    import bimc_pkg::*;

    t_q_status  mid_status, out_status;
    t_work_item mid_wdata, mid_rdata;
    logic       mid_push, mid_pop;
    t_out_item  out_wdata;
    logic       out_push, out_pop;

    bimc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .i_data     (i_data),
        .full       (full),
        .i_q_status (mid_status),
        .o_q_push   (mid_push),
        .o_q_item   (mid_wdata)
    );

    bimc_fifo #(.DEPTH(MID_DEPTH), .t_item(t_work_item)) u_mid_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (mid_push),
        .i_wdata  (mid_wdata),
        .i_pop    (mid_pop),
        .o_rdata  (mid_rdata),
        .o_status (mid_status)
    );

    bimc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_mid_status (mid_status),
        .i_mid_item   (mid_rdata),
        .o_mid_pop    (mid_pop),
        .i_out_status (out_status),
        .o_out_push   (out_push),
        .o_out_item   (out_wdata)
    );

    assign out_pop = pop && !out_status.empty;

    bimc_fifo #(.DEPTH(OUT_DEPTH), .t_item(t_out_item)) u_out_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (out_push),
        .i_wdata  (out_wdata),
        .i_pop    (out_pop),
        .o_rdata  (o_result),
        .o_status (out_status)
    );

    assign empty = out_status.empty;

endmodule
